// File: sv/ptbl_pkg.sv
// Page table package: table geometry, request codes and index/frame helpers.
// No dependencies; imported by the page table top level.
package ptbl_pkg;

  localparam int LEVEL1_BITS = 4;
  localparam int LEVEL2_BITS = 4;
  localparam int OFFSET_BITS = 8;
  localparam int FRAME_BITS  = 8;

  localparam int INDEX_BITS  = LEVEL1_BITS + LEVEL2_BITS;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;

  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [FRAME_BITS-1:0] frame_t;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  function automatic idx_t table_index(logic [15:0] addr);
    logic [31:0] a;
    a = 32'(addr) >> OFFSET_BITS;
    return a[INDEX_BITS-1:0];
  endfunction

  function automatic frame_t frame_cut(logic [7:0] f);
    logic [39:0] w;
    w = 40'(f);
    return w[FRAME_BITS-1:0];
  endfunction

endpackage

// File: sv/ptbl_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies; holds the page table frame store.
module ptbl_ram #(
  parameter int ADDR_BITS = 8,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/two_level_page_table.sv
// Two-level page table top level: request sequencer, valid bits and counters.
// Depends on ptbl_pkg and ptbl_ram.
//
// Usage: present a word on in_req_type, in_virt_address and in_frame_number
// and raise start; the word is taken at a clock edge with start high and
// busy low. Each word gives exactly one result word, shown for one cycle
// with out_valid high on out_hit, out_found_frame, out_hit_count and
// out_access_count. The receiver cannot hold results off; none is needed,
// since the next result never comes before the current one has gone.
// Flow, from the accepting edge to the edge that takes the result:
//   insert and unused codes: result registered at the accepting edge, a new word may follow at once;
//   lookup: busy for one cycle in ST_LOOKUP while the frame RAM is read;
//   remove: busy in ST_SCAN, one entry a cycle through the frame RAM read port,
//   until the first valid entry with that frame is found or the last entry is checked.
// Reset (rst_n low, synchronous) clears all valid bits and both counters at
// once; the frame RAM is not cleared, as a frame is only read under its
// valid bit. The block is ready in the cycle after reset.
module two_level_page_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_virt_address,
  input  logic [7:0]  in_frame_number,
  output logic        out_valid,
  output logic        out_hit,
  output logic [7:0]  out_found_frame,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_access_count
);
  import ptbl_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_LOOKUP, ST_SCAN} state_t;

  state_t               state_r, state_nxt;
  logic [TABLE_DEPTH-1:0] valid_r;
  idx_t                 idx_r, idx_nxt;
  frame_t               frame_r, frame_nxt;
  idx_t                 chk_r, chk_nxt;
  logic [31:0]          hits_r, hits_nxt;
  logic [31:0]          lookups_r, lookups_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [7:0]           out_frame_r, out_frame_nxt;

  idx_t                 in_idx;
  frame_t               in_frame;
  logic                 ram_we;
  idx_t                 rd_addr;
  frame_t               rd_data;
  logic                 vld_set;
  logic                 vld_clr;
  idx_t                 vld_idx;
  logic                 match;

  assign in_idx   = table_index(in_virt_address);
  assign in_frame = frame_cut(in_frame_number);
  assign match    = valid_r[chk_r] && (rd_data == frame_r);

  ptbl_ram #(
    .ADDR_BITS(INDEX_BITS),
    .DATA_BITS(FRAME_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_idx),
    .wdata(in_frame),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    frame_nxt     = frame_r;
    chk_nxt       = chk_r;
    hits_nxt      = hits_r;
    lookups_nxt   = lookups_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = 1'b0;
    out_frame_nxt = 8'd0;
    ram_we        = 1'b0;
    rd_addr       = idx_r;
    vld_set       = 1'b0;
    vld_clr       = 1'b0;
    vld_idx       = chk_r;
    unique case (state_r)
      ST_IDLE: begin
        rd_addr = (in_req_type == REQ_REMOVE) ? '0 : in_idx;
        vld_idx = in_idx;
        if (start) begin
          idx_nxt   = in_idx;
          frame_nxt = in_frame;
          chk_nxt   = '0;
          unique case (in_req_type)
            REQ_LOOKUP: state_nxt = ST_LOOKUP;
            REQ_INSERT: begin
              ram_we        = 1'b1;
              vld_set       = 1'b1;
              out_valid_nxt = 1'b1;
            end
            REQ_REMOVE: state_nxt = ST_SCAN;
            default:    out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_LOOKUP: begin
        lookups_nxt   = lookups_r + 32'd1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (valid_r[idx_r]) begin
          hits_nxt      = hits_r + 32'd1;
          out_hit_nxt   = 1'b1;
          out_frame_nxt = 8'(rd_data);
        end
      end
      ST_SCAN: begin
        rd_addr = chk_r + 1'b1;
        if (match || (chk_r == '1)) begin
          vld_clr       = match;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          chk_nxt = chk_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      hits_r      <= '0;
      lookups_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hits_r      <= hits_nxt;
      lookups_r   <= lookups_nxt;
      out_valid_r <= out_valid_nxt;
      if (vld_set) begin
        valid_r[vld_idx] <= 1'b1;
      end else if (vld_clr) begin
        valid_r[vld_idx] <= 1'b0;
      end
    end
    idx_r       <= idx_nxt;
    frame_r     <= frame_nxt;
    chk_r       <= chk_nxt;
    out_hit_r   <= out_hit_nxt;
    out_frame_r <= out_frame_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_found_frame  = out_frame_r;
  assign out_hit_count    = hits_r;
  assign out_access_count = lookups_r;

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the two-level page table: priming pass, directed table, then random words.
// Depends on ptbl_pkg and two_level_page_table; checked against an own table model or a row's result.
// Primes every frame slot once, so no scan or lookup ever touches an unwritten frame.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptbl_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 715;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;

  typedef struct packed {
    logic        hit;
    logic [7:0]  frame;
    logic [31:0] hits;
    logic [31:0] lookups;
  } result_t;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] addr;
    logic [7:0]  frame;
    logic        typed;
    result_t     res;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{REQ_LOOKUP, 16'h0000, 8'h00, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd1}},
    '{REQ_LOOKUP, 16'hFFFF, 8'hFF, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd2}},
    '{REQ_UNUSED, 16'hFFFF, 8'hFF, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd2}},
    '{REQ_INSERT, 16'h0000, 8'h00, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd2}},
    '{REQ_INSERT, 16'hFFFF, 8'hFF, 1'b1, '{1'b0, 8'h00, 32'd0, 32'd2}},
    '{REQ_LOOKUP, 16'h00FF, 8'h00, 1'b1, '{1'b1, 8'h00, 32'd1, 32'd3}},
    '{REQ_LOOKUP, 16'hFF00, 8'h00, 1'b1, '{1'b1, 8'hFF, 32'd2, 32'd4}},
    '{REQ_INSERT, 16'hFF12, 8'hA5, 1'b0, '0},
    '{REQ_LOOKUP, 16'hFFFF, 8'h00, 1'b0, '0},
    '{REQ_REMOVE, 16'h0000, 8'h77, 1'b1, '{1'b0, 8'h00, 32'd3, 32'd5}},
    '{REQ_INSERT, 16'h1234, 8'hA5, 1'b0, '0},
    '{REQ_REMOVE, 16'hFFFF, 8'hA5, 1'b0, '0},
    '{REQ_LOOKUP, 16'h1200, 8'h00, 1'b0, '0},
    '{REQ_LOOKUP, 16'hFF00, 8'h00, 1'b0, '0},
    '{REQ_REMOVE, 16'h0000, 8'hA5, 1'b0, '0},
    '{REQ_LOOKUP, 16'hFFAA, 8'h00, 1'b0, '0},
    '{REQ_REMOVE, 16'h1234, 8'h00, 1'b0, '0},
    '{REQ_LOOKUP, 16'h0000, 8'h00, 1'b0, '0},
    '{REQ_INSERT, 16'h5500, 8'h5A, 1'b0, '0},
    '{REQ_INSERT, 16'hAA00, 8'h5A, 1'b0, '0},
    '{REQ_REMOVE, 16'hFFFF, 8'h5A, 1'b0, '0},
    '{REQ_LOOKUP, 16'hAA00, 8'h00, 1'b0, '0},
    '{REQ_UNUSED, 16'h0000, 8'h00, 1'b1, '{1'b0, 8'h00, 32'd5, 32'd10}}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [15:0] in_virt_address;
  logic [7:0]  in_frame_number;
  logic        out_valid;
  logic        out_hit;
  logic [7:0]  out_found_frame;
  logic [31:0] out_hit_count;
  logic [31:0] out_access_count;

  logic        row_typed;
  result_t     row_result;

  bit          page_valid [TABLE_DEPTH];
  frame_t      page_frame [TABLE_DEPTH];
  logic [31:0] hit_total;
  logic [31:0] lookup_total;

  result_t     pending_results [$];
  int          mismatch_count;
  int          insert_tally;
  int          remove_tally;
  int          remove_match_tally;
  int          unused_tally;
  int          result_tally;

  two_level_page_table i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_virt_address  (in_virt_address),
    .in_frame_number  (in_frame_number),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_found_frame  (out_found_frame),
    .out_hit_count    (out_hit_count),
    .out_access_count (out_access_count)
  );

  always #5 clk = ~clk;

  function automatic result_t walk_table(logic [1:0] req, logic [15:0] addr,
                                         logic [7:0] frame);
    idx_t    slot;
    frame_t  fcut;
    result_t res;
    bit      done;
    slot = idx_t'(32'(addr) >> OFFSET_BITS);
    fcut = frame_t'(frame);
    res  = '0;
    done = 1'b0;
    case (req)
      REQ_LOOKUP: begin
        lookup_total = lookup_total + 32'd1;
        if (page_valid[slot]) begin
          hit_total = hit_total + 32'd1;
          res.hit   = 1'b1;
          res.frame = 8'(page_frame[slot]);
        end
      end
      REQ_INSERT: begin
        page_valid[slot] = 1'b1;
        page_frame[slot] = fcut;
        insert_tally++;
      end
      REQ_REMOVE: begin
        remove_tally++;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!done && page_valid[i] && page_frame[i] == fcut) begin
            page_valid[i] = 1'b0;
            done = 1'b1;
            remove_match_tally++;
          end
        end
      end
      default: begin
        unused_tally++;
      end
    endcase
    res.hits    = hit_total;
    res.lookups = lookup_total;
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_ports
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid) begin
        got = '{out_hit, out_found_frame, out_hit_count, out_access_count};
        result_tally++;
        if (pending_results.size() == 0) begin
          note_mismatch("result word with none pending, access_count", 32'd0, got.lookups);
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit)
            note_mismatch("hit", 32'(want.hit), 32'(got.hit));
          if (got.frame !== want.frame)
            note_mismatch("found_frame", 32'(want.frame), 32'(got.frame));
          if (got.hits !== want.hits)
            note_mismatch("hit_count", want.hits, got.hits);
          if (got.lookups !== want.lookups)
            note_mismatch("access_count", want.lookups, got.lookups);
        end
      end
      if (start && !busy) begin
        want = walk_table(in_req_type, in_virt_address, in_frame_number);
        if (row_typed) begin
          want = row_result;
        end
        pending_results.push_back(want);
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after the word is taken, start still high.
  task automatic send_word(logic [1:0] req, logic [15:0] addr, logic [7:0] frame,
                           logic typed, result_t res);
    start           = 1'b1;
    in_req_type     = req;
    in_virt_address = addr;
    in_frame_number = frame;
    row_typed       = typed;
    row_result      = res;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic hold_off(int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send_random_word();
    int         sel;
    idx_t       slot;
    logic [1:0] req;
    logic [15:0] addr;
    logic [7:0] frame;
    sel   = $urandom_range(99);
    addr  = 16'($urandom);
    frame = ($urandom_range(1) == 0) ? 8'($urandom) : 8'($urandom_range(15));
    if (sel < 40) req = REQ_LOOKUP;
    else if (sel < 70) req = REQ_INSERT;
    else if (sel < 95) req = REQ_REMOVE;
    else req = REQ_UNUSED;
    // aim most removes at a frame that is present
    if (req == REQ_REMOVE && $urandom_range(9) < 7) begin
      slot = idx_t'($urandom);
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        if (page_valid[slot]) begin
          frame = 8'(page_frame[slot]);
          break;
        end
        slot = slot + 1'b1;
      end
    end
    send_word(req, addr, frame, 1'b0, '0);
  endtask

  initial begin
    int guard;
    bit idle_on;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      page_valid[i] = 1'b0;
      page_frame[i] = '0;
    end
    hit_total       = '0;
    lookup_total    = '0;
    mismatch_count  = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_req_type     = REQ_LOOKUP;
    in_virt_address = '0;
    in_frame_number = '0;
    row_typed       = 1'b0;
    row_result      = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // write every frame slot once, then empty the table again
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_word(REQ_INSERT, 16'((i << OFFSET_BITS) | $urandom_range((1 << OFFSET_BITS) - 1)),
                8'(i), 1'b0, '0);
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_word(REQ_REMOVE, 16'($urandom), 8'(i), 1'b0, '0);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_word(DIRECTED[r].req, DIRECTED[r].addr, DIRECTED[r].frame,
                DIRECTED[r].typed, DIRECTED[r].res);
      if ($urandom_range(2) == 0) hold_off($urandom_range(1, 7));
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      idle_on = !((n >= 300 && n < 450) || n >= RANDOM_WORDS - 200);
      if (n == 600) begin
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      send_random_word();
      if (idle_on && $urandom_range(3) == 0) hold_off($urandom_range(1, 7));
    end

    start = 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 10 * TABLE_DEPTH) begin
      @(negedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $display("drain timed out with %0d results outstanding", pending_results.size());
      $display("tb: failure");
      $finish;
    end else begin
      repeat (SETTLE_CYCLES) @(negedge clk);
      if (pending_results.size() != 0) begin
        $display("%0d expected results never arrived", pending_results.size());
        mismatch_count += pending_results.size();
      end
      $display("run covered %0d result words: %0d lookups (%0d hits), %0d inserts,",
               result_tally, lookup_total, hit_total, insert_tally);
      $display("  %0d removes (%0d matched), %0d unused codes; %0d mismatches",
               remove_tally, remove_match_tally, unused_tally, mismatch_count);
      if (mismatch_count == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
      $finish;
    end
  end

  initial begin
    #15_000_000;
    $display("run timed out");
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
sv/ptbl_pkg.sv
sv/ptbl_ram.sv
sv/two_level_page_table.sv
bench/tb_top.sv
